// ===== sv/mtat_pkg.sv =====
// Package: shared types and constants of the masked time alarm table.
package mtat_pkg;

    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;
    localparam int IDX_OUT_W    = 4;
    localparam int RESULT_LIMIT = 16;
    localparam int NREP_W       = 5;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_REG  = 1'b1;

    localparam int MASK_SEC_BIT  = 0;
    localparam int MASK_MIN_BIT  = 1;
    localparam int MASK_HOUR_BIT = 2;

    typedef struct packed {
        logic [2:0] mask;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
    } t_entry;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_entry;
        logic stall;
        logic pend_valid;
        logic can_push;
    } t_status;

endpackage

// ===== sv/mtat_ctrl.sv =====
// Controller: sequences register writes, table scans and the final flush.
module mtat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    input  mtat_pkg::t_status i_status,
    output logic             o_in_ready,
    output mtat_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step  = (r_state == S_SCAN) && !i_status.stall;
        o_cmd.flush = (r_state == S_FLUSH) && (!i_status.pend_valid || i_status.can_push);
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load && (i_in_action == mtat_pkg::ACT_TICK)
                        && !i_status.count_zero) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (o_cmd.step && i_status.last_entry) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (o_cmd.flush) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/mtat_dpath.sv =====
// Datapath: alarm memory, fired latches, match logic and output register.
module mtat_dpath #(
    parameter int MAX_ALARMS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mtat_pkg::t_cmd                      i_cmd,
    input  logic                                i_action,
    input  logic [mtat_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic                                i_out_ready,
    output mtat_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    output logic [mtat_pkg::OUT_TDATA_W-1:0]    o_out_tdata,
    output logic                                o_out_last
);

    localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CW = $clog2(MAX_ALARMS + 1);
    localparam int EW = AW + mtat_pkg::IDX_OUT_W;

    mtat_pkg::t_entry r_mem [MAX_ALARMS];
    mtat_pkg::t_entry r_rd_data;
    mtat_pkg::t_entry in_entry;

    logic [MAX_ALARMS-1:0]            r_latch;
    logic [CW-1:0]                    r_count;
    logic [AW-1:0]                    r_idx;
    logic [4:0]                       r_tick_hour;
    logic [5:0]                       r_tick_minute;
    logic [5:0]                       r_tick_second;
    logic [mtat_pkg::NREP_W-1:0]      r_nrep;
    logic                             r_pend_valid;
    logic [mtat_pkg::IDX_OUT_W-1:0]   r_pend_idx;
    logic                             r_out_valid;
    logic [mtat_pkg::IDX_OUT_W-1:0]   r_out_idx;
    logic                             r_out_last;

    logic                             is_tick;
    logic                             not_full;
    logic                             wr_en;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic [2:0]                       hits;
    logic                             match;
    logic                             report;
    logic                             can_push;
    logic                             push;
    logic                             push_last;
    logic                             last_entry;
    logic [EW-1:0]                    idx_ext;
    logic [mtat_pkg::IDX_OUT_W-1:0]   idx4;

    always_comb begin
        in_entry.hour   = i_tdata[4:0];
        in_entry.minute = i_tdata[10:5];
        in_entry.second = i_tdata[16:11];
        in_entry.mask   = i_tdata[19:17];

        is_tick  = (i_action == mtat_pkg::ACT_TICK);
        not_full = (r_count < CW'(MAX_ALARMS));
        wr_en    = i_cmd.load && !is_tick && not_full;

        last_entry = (({1'b0, CW'(r_idx)} + (CW + 1)'(1)) == {1'b0, r_count});

        hits = '0;
        hits[mtat_pkg::MASK_HOUR_BIT] = (r_rd_data.hour == r_tick_hour);
        hits[mtat_pkg::MASK_MIN_BIT]  = (r_rd_data.minute == r_tick_minute);
        hits[mtat_pkg::MASK_SEC_BIT]  = (r_rd_data.second == r_tick_second);
        match  = ((hits & r_rd_data.mask) == r_rd_data.mask);
        report = match && !r_latch[r_idx] && (r_nrep < mtat_pkg::NREP_W'(mtat_pkg::RESULT_LIMIT));

        idx_ext = EW'(r_idx);
        idx4    = idx_ext[mtat_pkg::IDX_OUT_W-1:0];

        can_push  = !r_out_valid || i_out_ready;
        push      = r_pend_valid && ((i_cmd.step && report) || i_cmd.flush);
        push_last = i_cmd.flush;

        rd_en   = (i_cmd.load && is_tick) || (i_cmd.step && !last_entry);
        rd_addr = (i_cmd.load) ? '0 : r_idx + AW'(1);

        o_status.count_zero = (r_count == '0);
        o_status.last_entry = last_entry;
        o_status.stall      = report && r_pend_valid && !can_push;
        o_status.pend_valid = r_pend_valid;
        o_status.can_push   = can_push;
    end

    // alarm table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= in_entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && is_tick) begin
            r_tick_hour   <= in_entry.hour;
            r_tick_minute <= in_entry.minute;
            r_tick_second <= in_entry.second;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.step && report) begin
            r_pend_idx <= idx4;
        end
        if (push) begin
            r_out_idx  <= r_pend_idx;
            r_out_last <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch      <= '0;
            r_count      <= '0;
            r_nrep       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_latch[r_count[AW-1:0]] <= 1'b0;
                r_count                  <= r_count + CW'(1);
            end
            if (i_cmd.step) begin
                r_latch[r_idx] <= match;
            end
            if (i_cmd.load && is_tick) begin
                r_nrep       <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && report) begin
                r_nrep       <= r_nrep + mtat_pkg::NREP_W'(1);
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = mtat_pkg::OUT_TDATA_W'(r_out_idx);
    assign o_out_last  = r_out_last;

endmodule

// ===== sv/masked_time_alarm_table_top.sv =====
// Top level: masked time alarm table, controller plus datapath.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: hour, minute, second, mask
//                                                 tuser: action
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: alarm_index; tlast: last_of_run
//
//  A register word is written in idle without a scan. A tick word on a non-empty table scans the N stored alarms,
//  one alarm a cycle through the single read port of the table memory while the output is not stalled.
//  A new word is taken once the scan and the flush of the previous tick have finished.
//  Reset clears alarm count, fired latches and output valid; the table needs no clearing.
//  A stalled output holds the scan on the next firing alarm until a slot frees.
module masked_time_alarm_table_top #(
    parameter int MAX_ALARMS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [mtat_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // hour[4:0] minute[10:5] second[16:11] match_mask[19:17]
    input  logic                                i_s_axis_tuser,  // action
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mtat_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // alarm_index[3:0]
    output logic                                o_m_axis_tlast
);

    mtat_pkg::t_cmd    cmd;
    mtat_pkg::t_status status;

    mtat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_action (i_s_axis_tuser),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (cmd)
    );

    mtat_dpath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_s_axis_tuser),
        .i_tdata     (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_tdata (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

// ===== sv/mtat_checker.sv =====
// Checker: port-level properties of the alarm table, bound to the top level.
module mtat_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [mtat_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tlast
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_reg_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == mtat_pkg::ACT_REG)
            && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("register word produced a result");

endmodule

bind masked_time_alarm_table_top mtat_checker u_mtat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== test/masked_time_alarm_table_checker.sv =====
// Checker: predicts alarm firings from accepted input words and compares output words.
`timescale 1ns / 1ps

module masked_time_alarm_table_checker #(
    parameter int MAX_ALARMS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                i_s_axis_tready,
    input  logic [mtat_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // hour, minute, second, match_mask
    input  logic                                i_s_axis_tuser,  // action
    input  logic                                i_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [mtat_pkg::OUT_TDATA_W-1:0]    i_m_axis_tdata,  // alarm_index
    input  logic                                i_m_axis_tlast,  // last_of_run
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_ticks,
    output int                                  o_stored,
    output int                                  o_dropped,
    output int                                  o_fires
);

    typedef struct packed {
        logic [mtat_pkg::IDX_OUT_W-1:0] idx;
        logic                           last;
    } t_fire;

    mtat_pkg::t_entry      alarm_tab [MAX_ALARMS];
    logic [MAX_ALARMS-1:0] fired;
    int                    n_alarms;
    t_fire                 due_fires [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_ticks   = 0;
        o_stored  = 0;
        o_dropped = 0;
        o_fires   = 0;
        n_alarms  = 0;
        fired     = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic scan_tick(input mtat_pkg::t_entry tk);
        logic [2:0] hit;
        t_fire      run [$];
        t_fire      f;
        for (int i = 0; i < n_alarms; i++) begin
            hit = '0;
            hit[mtat_pkg::MASK_HOUR_BIT] = (alarm_tab[i].hour == tk.hour);
            hit[mtat_pkg::MASK_MIN_BIT]  = (alarm_tab[i].minute == tk.minute);
            hit[mtat_pkg::MASK_SEC_BIT]  = (alarm_tab[i].second == tk.second);
            if ((hit & alarm_tab[i].mask) == alarm_tab[i].mask) begin
                if (!fired[i]) begin
                    fired[i] = 1'b1;
                    if (run.size() < mtat_pkg::RESULT_LIMIT) begin
                        f.idx  = i[mtat_pkg::IDX_OUT_W-1:0];
                        f.last = 1'b0;
                        run.push_back(f);
                    end
                end
            end else begin
                fired[i] = 1'b0;
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[k])
            due_fires.push_back(run[k]);
    endtask

    always @(posedge i_clk) begin
        t_fire            want;
        mtat_pkg::t_entry w;
        if (!i_rst_n) begin
            n_alarms = 0;
            fired    = '0;
            due_fires.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_fires++;
                if (due_fires.size() == 0) begin
                    report_mismatch($sformatf("unexpected word index %0d last %0b",
                                              i_m_axis_tdata, i_m_axis_tlast));
                end else begin
                    want = due_fires.pop_front();
                    if (i_m_axis_tdata !==
                            {{(mtat_pkg::OUT_TDATA_W-mtat_pkg::IDX_OUT_W){1'b0}}, want.idx})
                        report_mismatch($sformatf("alarm_index got %0d want %0d",
                                                  i_m_axis_tdata, want.idx));
                    if (i_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last_of_run got %0b want %0b (index %0d)",
                                                  i_m_axis_tlast, want.last, want.idx));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                w = mtat_pkg::t_entry'(i_s_axis_tdata[$bits(mtat_pkg::t_entry)-1:0]);
                if (i_s_axis_tuser == mtat_pkg::ACT_REG) begin
                    if (n_alarms < MAX_ALARMS) begin
                        alarm_tab[n_alarms] = w;
                        fired[n_alarms]     = 1'b0;
                        n_alarms++;
                        o_stored++;
                    end else begin
                        o_dropped++;
                    end
                end else begin
                    o_ticks++;
                    scan_tick(w);
                end
            end
        end
        o_pending = due_fires.size();
    end

endmodule

// ===== test/masked_time_alarm_table_top_tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the masked time alarm table.
`timescale 1ns / 1ps

module masked_time_alarm_table_top_tb;

    localparam int MAX_ALARMS = 16;
    localparam int N_RANDOM   = 143;
    localparam int STALL_PCT  = 17;
    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN_WAIT = 40;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [mtat_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;   // hour, minute, second, match_mask
    logic                             i_s_axis_tuser;   // action
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [mtat_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;   // alarm_index
    logic                             o_m_axis_tlast;

    int               errors, pending, ticks, stored, dropped, fires;
    int               idle_cycles;
    logic             quiet;
    mtat_pkg::t_entry pool [$];
    mtat_pkg::t_entry prev_tick;

    masked_time_alarm_table_top #(
        .MAX_ALARMS(MAX_ALARMS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    masked_time_alarm_table_checker #(
        .MAX_ALARMS(MAX_ALARMS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_ticks         (ticks),
        .o_stored        (stored),
        .o_dropped       (dropped),
        .o_fires         (fires)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk)
        i_m_axis_tready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic act, input logic [4:0] hr, input logic [5:0] mn,
                             input logic [5:0] sc, input logic [2:0] msk);
        mtat_pkg::t_entry w;
        w = '{mask: msk, second: sc, minute: mn, hour: hr};
        while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(mtat_pkg::IN_TDATA_W - $bits(mtat_pkg::t_entry)){1'b0}}, w};
        i_s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (act == mtat_pkg::ACT_REG && pool.size() < MAX_ALARMS)
            pool.push_back(w);
        if (act == mtat_pkg::ACT_TICK)
            prev_tick = w;
    endtask

    initial begin
        mtat_pkg::t_entry base;
        int               r;
        logic [4:0]       hr;
        logic [5:0]       mn, sc;

        idle_cycles     = 0;
        quiet           = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= mtat_pkg::ACT_TICK;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then extremes and the always-match mask
        send_word(mtat_pkg::ACT_TICK, 5'd0,  6'd0,  6'd0,  3'd7);
        send_word(mtat_pkg::ACT_REG,  5'd0,  6'd0,  6'd0,  3'd7);
        send_word(mtat_pkg::ACT_REG,  5'd31, 6'd63, 6'd63, 3'd7);
        send_word(mtat_pkg::ACT_REG,  5'd9,  6'd17, 6'd3,  3'd0);
        send_word(mtat_pkg::ACT_TICK, 5'd0,  6'd0,  6'd0,  3'd0);
        send_word(mtat_pkg::ACT_TICK, 5'd0,  6'd0,  6'd0,  3'd5);
        send_word(mtat_pkg::ACT_TICK, 5'd31, 6'd63, 6'd63, 3'd2);
        send_word(mtat_pkg::ACT_TICK, 5'd0,  6'd0,  6'd0,  3'd0);
        // one alarm per partial mask
        send_word(mtat_pkg::ACT_REG,  5'd12, 6'd1,  6'd2,  3'd4);
        send_word(mtat_pkg::ACT_REG,  5'd3,  6'd30, 6'd2,  3'd2);
        send_word(mtat_pkg::ACT_REG,  5'd3,  6'd1,  6'd45, 3'd1);
        send_word(mtat_pkg::ACT_REG,  5'd12, 6'd30, 6'd7,  3'd6);
        send_word(mtat_pkg::ACT_REG,  5'd12, 6'd8,  6'd45, 3'd5);
        send_word(mtat_pkg::ACT_REG,  5'd1,  6'd30, 6'd45, 3'd3);
        send_word(mtat_pkg::ACT_TICK, 5'd12, 6'd30, 6'd45, 3'd0);
        send_word(mtat_pkg::ACT_TICK, 5'd12, 6'd31, 6'd45, 3'd0);
        send_word(mtat_pkg::ACT_TICK, 5'd12, 6'd30, 6'd45, 3'd0);
        // fill the table, then overflow
        for (int i = 0; i < 7; i++)
            send_word(mtat_pkg::ACT_REG, 5'd20, 6'd10, 6'd5, 3'd7);
        send_word(mtat_pkg::ACT_REG,  5'd5,  6'd5,  6'd5,  3'd7);
        send_word(mtat_pkg::ACT_TICK, 5'd20, 6'd10, 6'd5,  3'd7);
        send_word(mtat_pkg::ACT_TICK, 5'd5,  6'd5,  6'd5,  3'd7);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 60 && n < 110);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_word(mtat_pkg::ACT_REG, 5'($urandom), 6'($urandom), 6'($urandom),
                          3'($urandom));
            end else if (r < 30) begin
                send_word(mtat_pkg::ACT_TICK, prev_tick.hour, prev_tick.minute,
                          prev_tick.second, 3'($urandom));
            end else if (r < 85) begin
                base = pool[$urandom_range(0, pool.size() - 1)];
                hr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : base.hour;
                mn = ($urandom_range(0, 3) == 0) ? 6'($urandom) : base.minute;
                sc = ($urandom_range(0, 3) == 0) ? 6'($urandom) : base.second;
                send_word(mtat_pkg::ACT_TICK, hr, mn, sc, 3'($urandom));
            end else begin
                send_word(mtat_pkg::ACT_TICK, 5'($urandom), 6'($urandom), 6'($urandom),
                          3'($urandom));
            end
        end
        quiet = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d ticks against %0d stored alarms, %0d registrations dropped",
                 ticks, stored, dropped);
        $display("on a full table, %0d firing words checked, %0d mismatches", fires, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== masked_time_alarm_table_top.f =====
sv/mtat_pkg.sv
sv/mtat_ctrl.sv
sv/mtat_dpath.sv
sv/masked_time_alarm_table_top.sv
sv/mtat_checker.sv
test/masked_time_alarm_table_checker.sv
test/masked_time_alarm_table_top_tb.sv
